// ===== rtl/ucb_pkg.sv =====
package ucb_pkg;

  localparam int unsigned MAX_EDGES_DEF = 64;
  localparam logic [15:0] WEIGHT_RST    = 16'd5793;
  localparam logic [15:0] LN2_Q16       = 16'd45426;
  localparam logic [47:0] SCORE_MAX     = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SCORE_MIN     = 48'h8000_0000_0000;

  typedef struct packed {
    logic               child_present;
    logic [31:0]        child_visits;
    logic signed [47:0] child_value_sum;
    logic [31:0]        parent_visits;
    logic               last_edge;
  } in_t;

  typedef struct packed {
    logic [5:0] best_edge;
    logic       best_unvisited;
  } out_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_NORM   = 8'b0000_0010,
    ST_LNMUL  = 8'b0000_0100,
    ST_RATIO  = 8'b0000_1000,
    ST_SQRT   = 8'b0001_0000,
    ST_MULX   = 8'b0010_0000,
    ST_SCORE  = 8'b0100_0000,
    ST_DECIDE = 8'b1000_0000
  } state_t;

  // log2 of 1.f in Q16 for the four bits below the leading one
  function automatic logic [15:0] log2_frac(input logic [3:0] f);
    logic [15:0] r;
    case (f)
      4'd0:    r = 16'd0;
      4'd1:    r = 16'd5732;
      4'd2:    r = 16'd11136;
      4'd3:    r = 16'd16248;
      4'd4:    r = 16'd21098;
      4'd5:    r = 16'd25711;
      4'd6:    r = 16'd30109;
      4'd7:    r = 16'd34312;
      4'd8:    r = 16'd38336;
      4'd9:    r = 16'd42196;
      4'd10:   r = 16'd45904;
      4'd11:   r = 16'd49472;
      4'd12:   r = 16'd52911;
      4'd13:   r = 16'd56229;
      4'd14:   r = 16'd59434;
      default: r = 16'd62534;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ucb_div.sv =====
module ucb_div import ucb_pkg::*; #(
  parameter int unsigned NW = 56,
  parameter int unsigned DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem_r, num_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      num_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one quotient bit per cycle, restoring
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DW-1:0];
        num_nxt = {num_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        num_nxt = {num_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign quotient = num_r;

endmodule

// ===== rtl/ucb_sqrt.sv =====
module ucb_sqrt import ucb_pkg::*; #(
  parameter int unsigned VW = 38
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [VW-1:0]   value,
  output logic            busy,
  output logic [VW/2-1:0] root
);

  localparam int unsigned RW    = VW / 2;
  localparam int unsigned REM_W = RW + 2;
  localparam int unsigned CW    = $clog2(RW + 1);

  logic [VW-1:0]    val_r;
  logic [REM_W-1:0] rem_r;
  logic [RW-1:0]    root_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic [REM_W+1:0] r2;
  logic [REM_W+1:0] trial;

  assign r2    = {rem_r, val_r[VW-1:VW-2]};
  assign trial = (REM_W + 2)'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(RW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // two radicand bits per cycle, one root bit out
  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r <= {val_r[VW-3:0], 2'b00};
      if (r2 >= trial) begin
        rem_r  <= REM_W'(r2 - trial);
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        rem_r  <= REM_W'(r2);
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// ===== rtl/ucb1_child_select.sv =====
// UCB1 child selection. Feed the edges of one node one per transfer; the
// transfer marked last_edge yields one result with the index of the edge of
// highest score (earliest wins ties, unvisited edges win outright). A scored
// edge goes through the leading-one search, the ln multiply, a bit-serial
// ratio divider and a square root unit while a bit-serial mean divider
// runs beside them, then through the scaling, summing and comparison
// states. An edge that needs no score (unvisited, no child, an unvisited
// leader, or past MAX_EDGES) goes from the idle state straight to the
// decision state. The result register lets the next edge enter while a
// result waits.
module ucb1_child_select import ucb_pkg::*; #(
  parameter int unsigned MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data
);

  localparam int unsigned IDX_W = $clog2(MAX_EDGES);
  localparam int unsigned POS_W = $clog2(MAX_EDGES + 1);

  state_t state_r;

  logic [15:0]      weight_r;
  logic [POS_W-1:0] pos_r;
  logic [IDX_W-1:0] lead_idx_r;
  logic [47:0]      lead_score_r;
  logic             lead_inf_r;
  logic             out_valid_r;
  out_t             out_r;

  logic             inf_r, last_r, neg_r;
  logic [31:0]      visits_r;
  logic [32:0]      x_r;
  logic [5:0]       k_r;
  logic [47:0]      mean_r;
  logic [22:0]      explore_r;
  logic [47:0]      score_r;

  logic             accept;
  logic             in_range;
  logic             inf_in;
  logic             need_score;
  logic [47:0]      mag;

  logic             mean_start, mean_busy;
  logic [55:0]      mean_q;
  logic             ratio_start, ratio_busy;
  logic [36:0]      ratio_q;
  logic             sqrt_start, sqrt_busy;
  logic [18:0]      root;

  logic [21:0]      l2;
  logic [37:0]      ln_prod;
  logic [20:0]      ln;
  logic [34:0]      wprod;
  logic [47:0]      mean_sat;
  logic [48:0]      sum;
  logic             take;
  logic             out_free;
  logic             res_load;
  logic [IDX_W-1:0] idx_new;
  logic [IDX_W+5:0] idx_ext;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign in_range = (pos_r < POS_W'(MAX_EDGES));
  assign inf_in   = !in_data.child_present || (in_data.child_visits == 32'd0);
  assign need_score = in_range && !inf_in && !(lead_inf_r && pos_r != '0);
  assign mag = in_data.child_value_sum[47] ? (48'd0 - in_data.child_value_sum)
                                           : in_data.child_value_sum;

  assign mean_start  = accept && need_score;
  assign ratio_start = (state_r == ST_LNMUL);
  assign sqrt_start  = (state_r == ST_RATIO) && !ratio_busy;

  ucb_div #(.NW(56), .DW(32)) u_mean_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mean_start),
    .dividend ({mag, 8'd0}),
    .divisor  (in_data.child_visits),
    .busy     (mean_busy),
    .quotient (mean_q)
  );

  assign l2      = {k_r, 16'd0} + 22'(log2_frac(x_r[31:28]));
  assign ln_prod = l2 * LN2_Q16;
  assign ln      = ln_prod[36:16];

  ucb_div #(.NW(37), .DW(33)) u_ratio_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ratio_start),
    .dividend ({ln, 16'd0}),
    .divisor  ({1'b0, visits_r} + 33'd1),
    .busy     (ratio_busy),
    .quotient (ratio_q)
  );

  ucb_sqrt #(.VW(38)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value ({1'b0, ratio_q}),
    .busy  (sqrt_busy),
    .root  (root)
  );

  assign wprod = weight_r * root;

  always_comb begin
    if (neg_r) begin
      mean_sat = (mean_q > {8'd0, SCORE_MIN}) ? SCORE_MIN : (48'd0 - mean_q[47:0]);
    end else begin
      mean_sat = (mean_q > {8'd0, SCORE_MAX}) ? SCORE_MAX : mean_q[47:0];
    end
  end

  assign sum = {mean_r[47], mean_r} + 49'(explore_r);

  always_comb begin
    take = 1'b0;
    if (in_range) begin
      if (pos_r == '0) begin
        take = 1'b1;
      end else if (lead_inf_r) begin
        take = 1'b0;
      end else if (inf_r) begin
        take = 1'b1;
      end else begin
        take = $signed(score_r) > $signed(lead_score_r);
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign res_load = (state_r == ST_DECIDE) && last_r && out_free;
  assign idx_new  = take ? IDX_W'(pos_r) : lead_idx_r;
  assign idx_ext  = {6'd0, idx_new};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      weight_r     <= WEIGHT_RST;
      pos_r        <= '0;
      lead_idx_r   <= '0;
      lead_score_r <= '0;
      lead_inf_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        weight_r <= cfg_wdata;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= need_score ? ST_NORM : ST_DECIDE;
          end
        end
        ST_NORM: begin
          if (x_r[32]) begin
            state_r <= ST_LNMUL;
          end
        end
        ST_LNMUL: state_r <= ST_RATIO;
        ST_RATIO: begin
          if (!ratio_busy) begin
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (!sqrt_busy && !mean_busy) begin
            state_r <= ST_MULX;
          end
        end
        ST_MULX:  state_r <= ST_SCORE;
        ST_SCORE: state_r <= ST_DECIDE;
        ST_DECIDE: begin
          if (!last_r || out_free) begin
            state_r <= ST_IDLE;
            if (last_r) begin
              pos_r        <= '0;
              lead_idx_r   <= '0;
              lead_score_r <= '0;
              lead_inf_r   <= 1'b0;
            end else begin
              if (in_range) begin
                pos_r <= pos_r + POS_W'(1);
              end
              if (take) begin
                lead_idx_r   <= idx_new;
                lead_score_r <= inf_r ? 48'd0 : score_r;
                lead_inf_r   <= inf_r;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inf_r    <= inf_in;
      last_r   <= in_data.last_edge;
      neg_r    <= in_data.child_value_sum[47];
      visits_r <= in_data.child_visits;
      x_r      <= {1'b0, in_data.parent_visits} + 33'd1;
      k_r      <= 6'd32;
    end else if (state_r == ST_NORM && !x_r[32]) begin
      // shift toward the top until the leading one lands at bit 32
      x_r <= {x_r[31:0], 1'b0};
      k_r <= k_r - 6'd1;
    end
    if (state_r == ST_MULX) begin
      mean_r    <= mean_sat;
      explore_r <= wprod[34:12];
    end
    if (state_r == ST_SCORE) begin
      score_r <= (!sum[48] && sum[47]) ? SCORE_MAX : sum[47:0];
    end
    if (res_load) begin
      out_r.best_edge      <= idx_ext[5:0];
      out_r.best_unvisited <= take ? inf_r : lead_inf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
